[sv/vpc_pkg.sv]
`timescale 1ns / 1ps
// Package for the video processor CPU port.
// Holds the bus codes, register constants, controller state type and the
// command struct from the controller to the datapath. Depends on nothing.
package vpc_pkg;

  // VRAM depth by default; the depth must be a power of two.
  localparam int VRAM_BYTES_DEFAULT = 16384;

  // Width of the VDP access address.
  localparam int ADDR_W = 14;

  // Bus action codes.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Port select codes.
  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CTRL = 1'b1;

  // Bit 7 of the second control byte selects a register write.
  localparam int REG_WRITE_BIT = 7;
  // High address bits carried by the second control byte.
  localparam logic [7:0] ADDR_HI_MASK = 8'h3F;
  // Register 1 holds the interrupt enable in bit 5.
  localparam logic [2:0] REG_MODE1 = 3'd1;
  localparam int IRQ_EN_BIT = 5;
  // Status byte carries the frame flag in bit 7.
  localparam int STATUS_FLAG_BIT = 7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } vpc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // A transaction is accepted at this edge.
    logic load_out;  // Load the result register.
  } vpc_cmd_t;

endpackage

[sv/vpc_if.sv]
`timescale 1ns / 1ps
// Handshake interfaces for the video processor CPU port.
// The request channel carries bus accesses, the response channel results.
// Depends on nothing.
interface vpc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       port_select;
  logic [7:0] data_in;

  modport source(output valid, action, port_select, data_in, input ready);
  modport sink(input valid, action, port_select, data_in, output ready);
endinterface

interface vpc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;

  modport source(output valid, read_data, irq, input ready);
  modport sink(input valid, read_data, irq, output ready);
endinterface

[sv/vpc_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the video processor CPU port: VRAM, address and control
// registers, frame flag and the result register.
// Depends on vpc_pkg.
module vpc_datapath #(
  parameter int VRAM_BYTES = vpc_pkg::VRAM_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  vpc_pkg::vpc_cmd_t cmd,
  input  logic [1:0]       action,
  input  logic             port_select,
  input  logic [7:0]       data_in,
  output logic [7:0]       read_data,
  output logic             irq
);
  import vpc_pkg::*;

  localparam int MEM_AW = $clog2(VRAM_BYTES);

  // Architectural state.
  logic [ADDR_W-1:0] access_address, access_address_next;
  logic              latch_pending, latch_pending_next;
  logic [7:0]        latched_byte, latched_byte_next;
  logic [7:0]        regs [8];
  logic [7:0]        regs_next [8];
  logic              frame_flag, frame_flag_next;

  // VRAM and the values held from the acceptance of a transaction to its result.
  logic [7:0]        mem [VRAM_BYTES];
  logic [7:0]        mem_q;
  logic              sel_mem, sel_mem_next;
  logic [7:0]        status_q, status_next;
  logic              irq_q, irq_next;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_idx;

  // The address wraps modulo the power-of-two VRAM depth.
  assign mem_idx = access_address[MEM_AW-1:0];

  // Next state for the accepted transaction.
  always_comb begin
    access_address_next = access_address;
    latch_pending_next  = latch_pending;
    latched_byte_next   = latched_byte;
    frame_flag_next     = frame_flag;
    for (int i = 0; i < 8; i++) begin
      regs_next[i] = regs[i];
    end
    mem_we       = 1'b0;
    sel_mem_next = 1'b0;
    status_next  = '0;
    case (action)
      ACT_WRITE: begin
        if (port_select == PORT_DATA) begin
          mem_we              = 1'b1;
          access_address_next = access_address + ADDR_W'(1);
          latch_pending_next  = 1'b0;
        end else if (!latch_pending) begin
          latched_byte_next  = data_in;
          latch_pending_next = 1'b1;
        end else begin
          latch_pending_next = 1'b0;
          if (data_in[REG_WRITE_BIT]) begin
            regs_next[data_in[2:0]] = latched_byte;
          end else begin
            access_address_next = ADDR_W'({data_in & ADDR_HI_MASK, latched_byte});
          end
        end
      end
      ACT_READ: begin
        latch_pending_next = 1'b0;
        if (port_select == PORT_DATA) begin
          sel_mem_next        = 1'b1;
          access_address_next = access_address + ADDR_W'(1);
        end else begin
          status_next[STATUS_FLAG_BIT] = frame_flag;
          frame_flag_next              = 1'b0;
        end
      end
      ACT_TICK: begin
        frame_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
    irq_next = frame_flag_next & regs_next[REG_MODE1][IRQ_EN_BIT];
  end

  // Control state, updated when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      access_address <= '0;
      latch_pending  <= 1'b0;
      latched_byte   <= '0;
      frame_flag     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= '0;
      end
    end else if (cmd.start) begin
      access_address <= access_address_next;
      latch_pending  <= latch_pending_next;
      latched_byte   <= latched_byte_next;
      frame_flag     <= frame_flag_next;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= regs_next[i];
      end
    end
  end

  // VRAM port: one registered read per transaction, plus a write on a data write.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (mem_we) begin
        mem[mem_idx] <= data_in;
      end
      mem_q <= mem[mem_idx];
    end
  end

  // Per-transaction result fields, held until the result register loads.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sel_mem  <= sel_mem_next;
      status_q <= status_next;
      irq_q    <= irq_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data <= sel_mem ? mem_q : status_q;
      irq       <= irq_q;
    end
  end

endmodule

[sv/vpc_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the video processor CPU port: transaction sequencing and
// the valid flag of the result register.
// Depends on vpc_pkg.
module vpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vpc_pkg::vpc_cmd_t cmd
);
  import vpc_pkg::*;

  vpc_state_t state, state_next;
  logic       out_valid_next;

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands. In ST_IDLE a new transaction is taken once the result
  // register is free or is being emptied at the same edge.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.load_out = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready  = !out_valid || out_ready;
        cmd.start = in_valid && in_ready;
        if (cmd.start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.load_out   = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/video_processor_cpu_port.sv]
`timescale 1ns / 1ps
// Video processor CPU port, device side. An accepted transaction moves
// the controller to ST_EXEC, which loads the result and its valid flag
// and takes no new transaction, as the VRAM read is registered. A stalled
// result holds off transactions only while the result register is full.
// Reset (rst, synchronous) clears address, latch, registers and frame flag.
module video_processor_cpu_port #(
  parameter int VRAM_BYTES = vpc_pkg::VRAM_BYTES_DEFAULT
) (
  input logic  clk,
  input logic  rst,
  vpc_req_if.sink   req,
  vpc_rsp_if.source rsp
);
  import vpc_pkg::*;

  vpc_cmd_t cmd;

  // Transaction sequencing.
  vpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // VRAM, registers and result.
  vpc_datapath #(
    .VRAM_BYTES(VRAM_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (req.action),
    .port_select (req.port_select),
    .data_in     (req.data_in),
    .read_data   (rsp.read_data),
    .irq         (rsp.irq)
  );

  // An accepted transaction blocks the next one in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a transaction was in progress");

  // An accepted transaction yields a valid result, loaded in ST_EXEC.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> ##2 rsp.valid)
    else $error("result missing two cycles after accept");

  // The datapath is never told to start and load in the same cycle.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && cmd.load_out))
    else $error("start and load commands overlap");

endmodule
